[rtl/core/llacc_pkg.sv]
// shared constants, types and the softplus correction table
// no dependencies; every other file imports this package
package llacc_pkg;

    // number format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int EV_W       = 2;
    localparam int SUM_W      = 48;
    localparam int COUNT_W    = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CONTRIB_W  = DATA_W + 2;

    // softplus table geometry: |x| < 16 covered by LUT_ENTRIES segments
    localparam int LUT_ENTRIES = 256;
    localparam int LUT_BITS    = $clog2(LUT_ENTRIES);
    localparam int LUT_IDX_W   = LUT_BITS + 1;
    localparam int LUT_W       = FRAC_BITS;
    localparam int RANGE_BITS  = FRAC_BITS + 4;
    localparam int IDX_SHIFT   = RANGE_BITS - LUT_BITS;
    localparam int DROP_PROD_W = LUT_W + RANGE_BITS;

    // queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // event codes
    localparam logic [EV_W-1:0] EV_NONE  = EV_W'(0);
    localparam logic [EV_W-1:0] EV_EVENT = EV_W'(1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = CFG_IDX_W'(1);

    // scored point handed from front to back
    typedef struct packed {
        logic signed [CONTRIB_W-1:0] contrib;
        logic                        bad;
        logic                        last;
    } score_t;

    // queue status seen by front and back
    typedef struct packed {
        logic [QCOUNT_W-1:0] level;
        logic                empty;
    } queue_status_t;

    typedef logic [LUT_W-1:0] lut_t [LUT_ENTRIES + 1];

    // non-negative quotient by shift and subtract, used only while building the table
    function automatic longint div_q(longint num, longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | longint'(1);
            end
        end
        return quo;
    endfunction

    // ln(1+exp(-16*i/LUT_ENTRIES)) in Q30, rounded to FRAC_BITS fraction bits
    function automatic lut_t build_lut();
        lut_t   tab;
        longint q30_one;
        longint half;
        longint u;
        longint term;
        longint e;
        longint z;
        longint z2;
        longint p;
        longint s;
        longint ln;
        int     shift;
        q30_one = longint'(1) <<< 30;
        half    = longint'(1) <<< 29;
        shift   = 30 - FRAC_BITS;
        for (int i = 0; i <= LUT_ENTRIES; i++)
        begin
            u    = (longint'(i) <<< 26) >>> LUT_BITS;
            term = q30_one;
            e    = q30_one;
            for (int k = 1; k <= 10; k++)
            begin
                term = div_q((term * u) >>> 30, longint'(k));
                if (k[0])
                begin
                    e = e - term;
                end
                else
                begin
                    e = e + term;
                end
            end
            for (int k = 0; k < 8; k++)
            begin
                e = (e * e + half) >>> 30;
            end
            z  = div_q(e <<< 30, 2 * q30_one + e);
            z2 = (z * z + half) >>> 30;
            p  = z;
            s  = 0;
            for (int k = 0; k < 15; k++)
            begin
                s = s + div_q(p, longint'(2 * k + 1));
                p = (p * z2 + half) >>> 30;
            end
            ln     = 2 * s;
            tab[i] = LUT_W'((ln + (longint'(1) <<< (shift - 1))) >>> shift);
        end
        return tab;
    endfunction

    localparam lut_t SOFTPLUS_LUT = build_lut();

endpackage

[rtl/core/llacc_in_if.sv]
// data point channel: dose, event code and last marker
// depends on llacc_pkg
interface llacc_in_if import llacc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] dose;
    logic [EV_W-1:0]          event_req;
    logic                     last;

    modport source (output valid, dose, event_req, last, input ready);
    modport sink (input valid, dose, event_req, last, output ready);
endinterface

[rtl/core/llacc_out_if.sv]
// result channel: summed log-likelihood, point count, error flag
// depends on llacc_pkg
interface llacc_out_if import llacc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] log_likelihood;
    logic [COUNT_W-1:0]      points_counted;
    logic                    bad_event_seen;

    modport source (output valid, log_likelihood, points_counted, bad_event_seen, input ready);
    modport sink (input valid, log_likelihood, points_counted, bad_event_seen, output ready);
endinterface

[rtl/core/llacc_cfg_if.sv]
// register write channel: index and write data
// depends on llacc_pkg
interface llacc_cfg_if import llacc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/logistic_log_likelihood_accumulator_top.sv]
// an accepted point passes stage registers 1 to 4, the queue and (if last) the result register
// throughput: one point per cycle while the result side keeps up; the four-stage
// front pipeline and the accumulate in the back each take a beat a cycle
// an eight-entry queue decouples them; input ready drops when queue plus pipeline is full
// reset: rst_n async low clears config registers, pipeline valids, queue and accumulators
// no clearing pass; the softplus table is a constant built at elaboration
module logistic_log_likelihood_accumulator_top import llacc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    llacc_in_if.sink    points,
    llacc_cfg_if.sink   cfg,
    llacc_out_if.source result
);

    // front to queue
    logic          push;
    score_t        push_data;
    // queue to back
    logic          pop;
    score_t        pop_data;
    // shared view of queue fill: front uses level for credit, back uses empty
    queue_status_t qstat;

    // front: config registers, dose*slope, saturated eta, table softplus,
    // interpolation and per-point contribution; one beat per cycle while credit allows
    llacc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points),
        .cfg       (cfg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // short queue so the back can stall on the result side without
    // losing points that are already in the front pipeline
    llacc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    // back: saturating sum, saturating count, sticky bad-event flag;
    // result register on the last point of a set, then clear
    llacc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .result   (result)
    );

endmodule

[rtl/core/llacc_front.sv]
// front pipeline: config registers, eta, softplus, per-point contribution
// depends on llacc_pkg, llacc_in_if, llacc_cfg_if
module llacc_front import llacc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    llacc_in_if.sink      points,
    llacc_cfg_if.sink     cfg,
    input  queue_status_t qstat,
    output logic          push,
    output score_t        push_data
);

    localparam logic signed [DATA_W-1:0] ETA_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] ETA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    logic signed [DATA_W-1:0] intercept_reg;
    logic signed [DATA_W-1:0] slope_reg;
    logic [3:0]               stage_valid_reg;

    // stage 1: product
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [EV_W-1:0]          ev1_reg;
    logic                     last1_reg;
    // stage 2: saturated eta
    logic signed [DATA_W-1:0] eta2_reg;
    logic signed [DATA_W-1:0] eta2_next;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [PROD_W:0]   eta_sum;
    logic [EV_W-1:0]          ev2_reg;
    logic                     last2_reg;
    // stage 3: table lookup
    logic [DATA_W-1:0]        mag;
    logic                     in_range;
    logic [LUT_BITS-1:0]      seg;
    logic [LUT_IDX_W-1:0]     seg_lo;
    logic [LUT_IDX_W-1:0]     seg_hi;
    logic [LUT_W-1:0]         t_lo;
    logic [LUT_W-1:0]         t_hi;
    logic [DATA_W-2:0]        base3_reg;
    logic [LUT_W-1:0]         t0_3_reg;
    logic [LUT_W-1:0]         drop3_reg;
    logic [RANGE_BITS-1:0]    rem3_reg;
    logic signed [DATA_W-1:0] eta3_reg;
    logic [EV_W-1:0]          ev3_reg;
    logic                     last3_reg;
    // stage 4: interpolation product
    logic [DROP_PROD_W-1:0]   drop_prod;
    logic [LUT_W-1:0]         corr4_reg;
    logic [DATA_W-2:0]        base4_reg;
    logic [LUT_W-1:0]         t0_4_reg;
    logic signed [DATA_W-1:0] eta4_reg;
    logic [EV_W-1:0]          ev4_reg;
    logic                     last4_reg;
    // output of stage 4
    logic signed [CONTRIB_W-1:0] softplus_val;
    logic signed [CONTRIB_W-1:0] eta_ext;
    logic signed [CONTRIB_W-1:0] contrib;

    logic [QCOUNT_W:0] load;
    logic              accept;

    // credit: queue level plus points still in the pipeline
    assign load   = (QCOUNT_W + 1)'(qstat.level) + (QCOUNT_W + 1)'($countones(stage_valid_reg));
    assign points.ready = (load < (QCOUNT_W + 1)'(QUEUE_DEPTH));
    assign accept = points.valid && points.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intercept_reg   <= '0;
            slope_reg       <= '0;
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= {stage_valid_reg[2:0], accept};
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_INTERCEPT: intercept_reg <= cfg.data;
                    REG_SLOPE:     slope_reg     <= cfg.data;
                    default:       ;
                endcase
            end
        end
    end

    always_comb
    begin
        prod_next  = points.dose * slope_reg;
        prod_shift = prod_reg >>> FRAC_BITS;
        eta_sum    = (PROD_W + 1)'(intercept_reg) + (PROD_W + 1)'(prod_shift);
        if (eta_sum[PROD_W:DATA_W-1] == '0 || eta_sum[PROD_W:DATA_W-1] == '1)
        begin
            eta2_next = eta_sum[DATA_W-1:0];
        end
        else if (eta_sum[PROD_W])
        begin
            eta2_next = ETA_MIN;
        end
        else
        begin
            eta2_next = ETA_MAX;
        end
    end

    always_comb
    begin
        if (eta2_reg[DATA_W-1])
        begin
            mag = ~unsigned'(eta2_reg) + DATA_W'(1);
        end
        else
        begin
            mag = unsigned'(eta2_reg);
        end
        in_range = (mag[DATA_W-1:RANGE_BITS] == '0);
        seg      = mag[RANGE_BITS-1:IDX_SHIFT];
        seg_lo   = {1'b0, seg};
        seg_hi   = seg_lo + LUT_IDX_W'(1);
        t_lo     = SOFTPLUS_LUT[seg_lo];
        t_hi     = SOFTPLUS_LUT[seg_hi];
    end

    assign drop_prod = DROP_PROD_W'(drop3_reg) * DROP_PROD_W'(rem3_reg);

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        ev1_reg   <= points.event_req;
        last1_reg <= points.last;

        eta2_reg  <= eta2_next;
        ev2_reg   <= ev1_reg;
        last2_reg <= last1_reg;

        base3_reg <= eta2_reg[DATA_W-1] ? '0 : eta2_reg[DATA_W-2:0];
        t0_3_reg  <= in_range ? t_lo : '0;
        drop3_reg <= (in_range && t_lo >= t_hi) ? (t_lo - t_hi) : '0;
        rem3_reg  <= in_range ? {mag[IDX_SHIFT-1:0], LUT_BITS'(0)} : '0;
        eta3_reg  <= eta2_reg;
        ev3_reg   <= ev2_reg;
        last3_reg <= last2_reg;

        corr4_reg <= drop_prod[DROP_PROD_W-1:RANGE_BITS];
        base4_reg <= base3_reg;
        t0_4_reg  <= t0_3_reg;
        eta4_reg  <= eta3_reg;
        ev4_reg   <= ev3_reg;
        last4_reg <= last3_reg;
    end

    always_comb
    begin
        softplus_val = CONTRIB_W'(base4_reg) + CONTRIB_W'(t0_4_reg) - CONTRIB_W'(corr4_reg);
        eta_ext      = CONTRIB_W'(eta4_reg);
        case (ev4_reg)
            EV_EVENT: contrib = eta_ext - softplus_val;
            EV_NONE:  contrib = -softplus_val;
            default:  contrib = '0;
        endcase
    end

    assign push              = stage_valid_reg[3];
    assign push_data.contrib = contrib;
    assign push_data.bad     = (ev4_reg != EV_NONE) && (ev4_reg != EV_EVENT);
    assign push_data.last    = last4_reg;

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load <= (QCOUNT_W + 1)'(QUEUE_DEPTH))
        else $error("front credit exceeds queue depth");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stage_valid_reg[0])
        else $error("accepted point missing from pipeline");

    a_contrib_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data.contrib[CONTRIB_W-1] || push_data.contrib == '0))
        else $error("positive log-likelihood contribution");
`endif

endmodule

[rtl/core/llacc_queue.sv]
// short queue of scored points between front and back
// depends on llacc_pkg
module llacc_queue import llacc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  score_t        push_data,
    input  logic          pop,
    output score_t        pop_data,
    output queue_status_t qstat
);

    score_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg;
    logic [QCOUNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCOUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCOUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = mem[rd_ptr_reg];
    assign qstat.level = count_reg;
    assign qstat.empty = (count_reg == '0);

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCOUNT_W'(QUEUE_DEPTH)) || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCOUNT_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");
`endif

endmodule

[rtl/core/llacc_back.sv]
// back end: saturating accumulation, count, error flag, result register
// depends on llacc_pkg, llacc_out_if
module llacc_back import llacc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t qstat,
    input  score_t        pop_data,
    output logic          pop,
    llacc_out_if.source   result
);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic                    flag_reg;
    logic                    flag_next;
    logic signed [SUM_W:0]   sum_wide;

    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic [COUNT_W-1:0]      out_count_reg;
    logic                    out_flag_reg;

    // take a point whenever the result register is free or draining
    assign pop = !qstat.empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        sum_wide = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(pop_data.contrib);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                       : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
        count_next = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
        flag_next  = flag_reg || pop_data.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && pop_data.last)
            begin
                sum_reg       <= '0;
                count_reg     <= '0;
                flag_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (pop)
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    flag_reg  <= flag_next;
                end
                if (result.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_data.last)
        begin
            out_sum_reg   <= sum_next;
            out_count_reg <= count_next;
            out_flag_reg  <= flag_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.log_likelihood = out_sum_reg;
    assign result.points_counted = out_count_reg;
    assign result.bad_event_seen = out_flag_reg;

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_data.last) |=> (sum_reg == '0 && count_reg == '0 && !flag_reg))
        else $error("accumulators not cleared after last point");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !pop_data.last) |=> (count_reg != '0))
        else $error("point not counted");

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_data.last) |=> out_valid_reg)
        else $error("last point produced no result");
`endif

endmodule
